>>> design/pls_pkg.sv
package pls_pkg;

	// list length limit and the position counter that can hold it
	localparam int MAX_LIST_BYTES = 65536;
	localparam int POS_W          = $clog2(MAX_LIST_BYTES + 1);
	localparam int CFG_IDX_W      = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCCURRENCE = 2'd1;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ABSENT  = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	typedef enum logic [2:0] {
		PH_ID      = 3'd0,
		PH_FIXED   = 3'd1,
		PH_VARINT  = 3'd2,
		PH_PREFIX1 = 3'd3,
		PH_BODY1   = 3'd4,
		PH_PREFIX2 = 3'd5,
		PH_BODY2   = 3'd6,
		PH_STOP    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		K_BYTE    = 3'd0,
		K_TWO     = 3'd1,
		K_FOUR    = 3'd2,
		K_VARINT  = 3'd3,
		K_STRING  = 3'd4,
		K_DATA    = 3'd5,
		K_PAIR    = 3'd6,
		K_UNKNOWN = 3'd7
	} kind_t;

	typedef struct packed {
		logic [7:0] list_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic        found;
		logic [1:0]  status;
		logic [2:0]  value_type;
		logic [31:0] int_value;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} out_t;

	typedef struct packed {
		phase_t           phase;
		logic [15:0]      bytes_left;
		kind_t            kind;
		logic [7:0]       match_count;
		logic             is_match;
		logic [31:0]      value;
		logic [POS_W-1:0] pos;
		logic [15:0]      offset;
		logic [15:0]      length;
		logic [1:0]       status;
		logic [1:0]       vcount;
		logic [7:0]       prefix_high;
	} scan_state_t;

	localparam scan_state_t SCAN_CLEAR = '{
		phase:       PH_ID,
		bytes_left:  16'd0,
		kind:        K_BYTE,
		match_count: 8'd0,
		is_match:    1'b0,
		value:       32'd0,
		pos:         '0,
		offset:      16'd0,
		length:      16'd0,
		status:      ST_ABSENT,
		vcount:      2'd0,
		prefix_high: 8'd0
	};

	// property identifier to datatype, per the mqtt 5 property table
	function automatic kind_t kind_of(input logic [7:0] id);
		kind_t k;
		case (id)
			8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: k = K_BYTE;
			8'h13, 8'h21, 8'h22, 8'h23:                             k = K_TWO;
			8'h02, 8'h11, 8'h18, 8'h27:                             k = K_FOUR;
			8'h0B:                                                  k = K_VARINT;
			8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F:        k = K_STRING;
			8'h09, 8'h16:                                           k = K_DATA;
			8'h26:                                                  k = K_PAIR;
			default:                                                k = K_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

>>> design/pls_step.sv
module pls_step (
	input  pls_pkg::scan_state_t cur,
	input  pls_pkg::in_t         beat,
	input  logic [7:0]           target_id,
	input  logic [7:0]           occurrence,
	output pls_pkg::scan_state_t nxt,
	output pls_pkg::out_t        result
);
	import pls_pkg::*;

	logic        fin;
	kind_t       k;
	logic [15:0] len;
	logic [16:0] lsum;
	logic [17:0] psum;
	logic [4:0]  vsh;
	logic [15:0] pos_next16;

	always_comb begin
		nxt        = cur;
		fin        = 1'b0;
		k          = kind_of(beat.list_byte);
		len        = {cur.prefix_high, beat.list_byte};
		lsum       = {1'b0, cur.length} + 17'd1;
		psum       = {2'b00, cur.length} + {2'b00, len} + 18'd2;
		pos_next16 = 16'(cur.pos + POS_W'(1));
		case (cur.vcount)
			2'd0:    vsh = 5'd0;
			2'd1:    vsh = 5'd7;
			2'd2:    vsh = 5'd14;
			default: vsh = 5'd21;
		endcase

		if (cur.phase != PH_STOP) begin
			if (cur.pos >= POS_W'(MAX_LIST_BYTES)) begin
				nxt.phase  = PH_STOP;
				nxt.status = ST_TRUNC;
			end else begin
				nxt.pos = cur.pos + POS_W'(1);
				unique case (cur.phase)
					PH_ID: begin
						nxt.kind = k;
						if (k == K_UNKNOWN) begin
							nxt.phase  = PH_STOP;
							nxt.status = ST_UNKNOWN;
						end else begin
							nxt.is_match = (beat.list_byte == target_id);
							nxt.value    = 32'd0;
							nxt.length   = 16'd0;
							nxt.vcount   = 2'd0;
							nxt.offset   = pos_next16;
							if (k == K_BYTE || k == K_TWO || k == K_FOUR) begin
								nxt.bytes_left = (k == K_BYTE) ? 16'd1 :
									(k == K_TWO) ? 16'd2 : 16'd4;
								nxt.length     = nxt.bytes_left;
								nxt.phase      = PH_FIXED;
							end else if (k == K_VARINT) begin
								nxt.phase = PH_VARINT;
							end else begin
								nxt.phase = PH_PREFIX1;
							end
						end
					end
					PH_FIXED: begin
						nxt.value      = {cur.value[23:0], beat.list_byte};
						nxt.bytes_left = cur.bytes_left - 16'd1;
						fin            = (cur.bytes_left == 16'd1);
					end
					PH_VARINT: begin
						nxt.value  = cur.value | ({25'd0, beat.list_byte[6:0]} << vsh);
						nxt.length = lsum[16] ? 16'hFFFF : lsum[15:0];
						if (!beat.list_byte[7]) begin
							fin = 1'b1;
						end else if (cur.vcount == 2'd3) begin
							// continuation bit still set on the fourth byte
							nxt.phase  = PH_STOP;
							nxt.status = ST_TRUNC;
						end else begin
							nxt.vcount = cur.vcount + 2'd1;
						end
					end
					PH_PREFIX1, PH_PREFIX2: begin
						if (cur.vcount == 2'd0) begin
							nxt.prefix_high = beat.list_byte;
							nxt.vcount      = 2'd1;
						end else begin
							nxt.vcount = 2'd0;
							if (cur.kind != K_PAIR) begin
								nxt.offset = pos_next16;
								nxt.length = len;
							end else begin
								nxt.length = (psum > 18'd65535) ? 16'hFFFF : psum[15:0];
							end
							nxt.bytes_left = len;
							if (cur.phase == PH_PREFIX1) begin
								if (len != 16'd0)
									nxt.phase = PH_BODY1;
								else if (cur.kind == K_PAIR)
									nxt.phase = PH_PREFIX2;
								else
									fin = 1'b1;
							end else begin
								if (len != 16'd0)
									nxt.phase = PH_BODY2;
								else
									fin = 1'b1;
							end
						end
					end
					PH_BODY1: begin
						nxt.bytes_left = cur.bytes_left - 16'd1;
						if (cur.bytes_left == 16'd1) begin
							if (cur.kind == K_PAIR)
								nxt.phase = PH_PREFIX2;
							else
								fin = 1'b1;
						end
					end
					PH_BODY2: begin
						nxt.bytes_left = cur.bytes_left - 16'd1;
						fin            = (cur.bytes_left == 16'd1);
					end
					PH_STOP: begin
					end
					default: begin
					end
				endcase
			end
		end

		// property complete: count the match or stop on the wanted one
		if (fin) begin
			nxt.phase = PH_ID;
			if (cur.is_match) begin
				if (cur.match_count < occurrence) begin
					nxt.match_count = cur.match_count + 8'd1;
				end else begin
					nxt.phase  = PH_STOP;
					nxt.status = ST_OK;
				end
			end
		end

		result = '0;
		if (nxt.phase == PH_STOP && nxt.status == ST_OK) begin
			result.found          = 1'b1;
			result.status         = ST_OK;
			result.value_type     = nxt.kind;
			result.int_value      = (nxt.kind == K_BYTE || nxt.kind == K_TWO ||
				nxt.kind == K_FOUR || nxt.kind == K_VARINT) ? nxt.value : 32'd0;
			result.payload_offset = nxt.offset;
			result.payload_length = nxt.length;
		end else if (nxt.phase == PH_STOP) begin
			result.status = nxt.status;
		end else if (nxt.phase != PH_ID) begin
			result.status = ST_TRUNC;
		end else begin
			result.status = ST_ABSENT;
		end
	end

endmodule

>>> design/property_list_scanner_core.sv
// property list scanner: one list byte per beat, one result beat per list
// result beat: registered from the last byte, via the skid while the output stalls
// throughput: one byte per cycle while byte_stall is low; scan state updates in a single step per byte
// the output register plus a one-deep skid lets bytes keep flowing while a result waits
// reset: arst_n clears scan state, config regs and output valids at once; no clearing pass
module property_list_scanner_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  pls_pkg::in_t                    byte_beat,
	output logic                            result_valid,
	input  logic                            result_stall,
	output pls_pkg::out_t                   result_beat,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data
);
	import pls_pkg::*;

	// configuration registers
	logic [7:0] target_id_q;
	logic [7:0] occurrence_q;

	// scan state carried from byte to byte
	scan_state_t state_q;
	scan_state_t state_nxt;
	out_t        step_result;

	// output register and skid stage
	logic out_valid_q;
	out_t out_q;
	logic skid_valid_q;
	out_t skid_q;

	logic byte_fire;
	logic res_new;
	logic out_free;

	// config writes always land; the user must issue them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_id_q  <= 8'd0;
			occurrence_q <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TARGET_ID:  target_id_q  <= cfg_data;
				REG_OCCURRENCE: occurrence_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// per-byte state update
	pls_step u_step (
		.cur        (state_q),
		.beat       (byte_beat),
		.target_id  (target_id_q),
		.occurrence (occurrence_q),
		.nxt        (state_nxt),
		.result     (step_result)
	);

	// input only backs up once the skid holds a result
	assign byte_stall = skid_valid_q;
	assign byte_fire  = byte_valid && !byte_stall;
	assign res_new    = byte_fire && byte_beat.last_byte;
	assign out_free   = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_CLEAR;
		end else if (byte_fire) begin
			// last byte closes the list and starts the next one fresh
			state_q <= byte_beat.last_byte ? SCAN_CLEAR : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_new;
			skid_valid_q <= 1'b0;
		end else if (res_new) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (res_new)
				out_q <= step_result;
		end else if (res_new) begin
			skid_q <= step_result;
		end
	end

	assign result_valid = out_valid_q;
	assign result_beat  = out_q;

	// skid only fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while output register is empty");

	// a found result always reports ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_beat.found) |-> (result_beat.status == ST_OK))
		else $error("found result with non-ok status");

	// fields are zero when nothing was found
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_beat.found) |->
		(result_beat.int_value == 32'd0 && result_beat.payload_length == 16'd0 &&
		result_beat.payload_offset == 16'd0 && result_beat.value_type == 3'd0))
		else $error("not-found result carries value fields");

	// the scan restarts at position zero after every list
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_new |=> (state_q.pos == '0 && state_q.phase == PH_ID))
		else $error("scan state not cleared after last byte");

endmodule

>>> tb/scan_report_checker.sv
`timescale 1ns / 1ps

module scan_report_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	input  logic                          byte_stall,
	input  pls_pkg::in_t                  byte_beat,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  pls_pkg::out_t                 result_beat,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output int                            mismatches,
	output int                            reports_pending,
	output int                            reports_checked
);
	import pls_pkg::*;

	// register copies
	logic [7:0] want_id;
	logic [7:0] want_nth;

	// scan state of the list in flight
	phase_t      phase;
	kind_t       kind;
	int unsigned field_left;
	int unsigned list_pos;
	int unsigned value_offset;
	int unsigned value_span;
	logic [7:0]  nth_seen;
	logic        hit;
	logic [31:0] value;
	logic [1:0]  status;
	logic [1:0]  vcount;
	logic [7:0]  len_high;

	out_t awaited_reports[$];

	task automatic restart_scan();
		phase        = PH_ID;
		kind         = K_BYTE;
		field_left   = 0;
		list_pos     = 0;
		value_offset = 0;
		value_span   = 0;
		nth_seen     = '0;
		hit          = 1'b0;
		value        = '0;
		status       = ST_ABSENT;
		vcount       = '0;
		len_high     = '0;
	endtask

	task automatic grow_span(input int unsigned n);
		int unsigned s;
		s = value_span + n;
		value_span = (s > 32'd65535) ? 32'd65535 : s;
	endtask

	// a complete property either is the wanted match or bumps the match count
	task automatic close_property();
		if (hit && nth_seen == want_nth) begin
			phase  = PH_STOP;
			status = ST_OK;
		end else begin
			if (hit)
				nth_seen++;
			phase = PH_ID;
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic last);
		logic [15:0] len;
		out_t        rep;
		if (phase != PH_STOP) begin
			if (list_pos >= MAX_LIST_BYTES) begin
				phase  = PH_STOP;
				status = ST_TRUNC;
			end else begin
				case (phase)
					PH_ID: begin
						case (b)
							8'h01, 8'h17, 8'h19:        kind = K_BYTE;
							8'h24, 8'h25:               kind = K_BYTE;
							8'h28, 8'h29, 8'h2A:        kind = K_BYTE;
							8'h13, 8'h21, 8'h22, 8'h23: kind = K_TWO;
							8'h02, 8'h11, 8'h18, 8'h27: kind = K_FOUR;
							8'h0B:                      kind = K_VARINT;
							8'h03, 8'h08, 8'h12, 8'h15: kind = K_STRING;
							8'h1A, 8'h1C, 8'h1F:        kind = K_STRING;
							8'h09, 8'h16:               kind = K_DATA;
							8'h26:                      kind = K_PAIR;
							default:                    kind = K_UNKNOWN;
						endcase
						if (kind == K_UNKNOWN) begin
							phase  = PH_STOP;
							status = ST_UNKNOWN;
						end else begin
							hit          = (b == want_id);
							value        = '0;
							value_span   = 0;
							vcount       = '0;
							value_offset = list_pos + 32'd1;
							case (kind)
								K_BYTE, K_TWO, K_FOUR: begin
									field_left = (kind == K_BYTE) ? 32'd1 :
										(kind == K_TWO) ? 32'd2 : 32'd4;
									value_span = field_left;
									phase      = PH_FIXED;
								end
								K_VARINT: phase = PH_VARINT;
								default:  phase = PH_PREFIX1;
							endcase
						end
					end
					PH_FIXED: begin
						value = {value[23:0], b};
						field_left--;
						if (field_left == 0)
							close_property();
					end
					PH_VARINT: begin
						value = value | (32'(b[6:0]) << (7 * vcount));
						grow_span(32'd1);
						if (!b[7])
							close_property();
						else if (vcount == 2'd3) begin
							phase  = PH_STOP;
							status = ST_TRUNC;
						end else
							vcount++;
					end
					PH_PREFIX1, PH_PREFIX2: begin
						if (vcount == 2'd0) begin
							len_high = b;
							vcount   = 2'd1;
						end else begin
							vcount = 2'd0;
							len    = {len_high, b};
							if (kind != K_PAIR) begin
								value_offset = list_pos + 32'd1;
								value_span   = 32'(len);
							end else
								grow_span(32'd2 + 32'(len));
							field_left = 32'(len);
							if (len != 16'd0)
								phase = (phase == PH_PREFIX1) ? PH_BODY1 : PH_BODY2;
							else if (phase == PH_PREFIX1 && kind == K_PAIR)
								phase = PH_PREFIX2;
							else
								close_property();
						end
					end
					PH_BODY1, PH_BODY2: begin
						field_left--;
						if (field_left == 0) begin
							if (phase == PH_BODY1 && kind == K_PAIR)
								phase = PH_PREFIX2;
							else
								close_property();
						end
					end
					default: ;
				endcase
				list_pos++;
			end
		end
		if (last) begin
			rep = '0;
			if (phase == PH_STOP && status == ST_OK) begin
				rep.found          = 1'b1;
				rep.status         = ST_OK;
				rep.value_type     = kind;
				rep.int_value      = (kind <= K_VARINT) ? value : 32'd0;
				rep.payload_offset = value_offset[15:0];
				rep.payload_length = value_span[15:0];
			end else if (phase == PH_STOP)
				rep.status = status;
			else if (phase != PH_ID)
				rep.status = ST_TRUNC;
			else
				rep.status = ST_ABSENT;
			awaited_reports.insert(awaited_reports.size(), rep);
			restart_scan();
		end
	endtask

	task automatic flag_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: scan report %0d, %s: expected 0x%0h, got 0x%0h",
				$time, reports_checked, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_t head;
		if (!arst_n) begin
			want_id  = '0;
			want_nth = '0;
			restart_scan();
			awaited_reports.delete();
			mismatches      = 0;
			reports_checked = 0;
		end else begin
			// result beats come from earlier bytes, so compare before predicting
			if (result_valid && !result_stall) begin
				if (awaited_reports.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected scan report, expected none, got 0x%0h",
						$time, result_beat);
				end else begin
					head = awaited_reports.pop_front();
					flag_field("found", 32'(head.found), 32'(result_beat.found));
					flag_field("status", 32'(head.status), 32'(result_beat.status));
					flag_field("value_type", 32'(head.value_type),
						32'(result_beat.value_type));
					flag_field("int_value", head.int_value, result_beat.int_value);
					flag_field("payload_offset", 32'(head.payload_offset),
						32'(result_beat.payload_offset));
					flag_field("payload_length", 32'(head.payload_length),
						32'(result_beat.payload_length));
					reports_checked++;
				end
			end
			if (byte_valid && !byte_stall)
				scan_byte(byte_beat.list_byte, byte_beat.last_byte);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TARGET_ID)
					want_id = cfg_data;
				else if (cfg_index == REG_OCCURRENCE)
					want_nth = cfg_data;
			end
		end
		reports_pending = awaited_reports.size();
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import pls_pkg::*;

	// receiver hold-off used once to back the block up into its byte input
	localparam int LONG_HOLD = 80;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	in_t                  byte_beat;
	logic                 result_valid;
	logic                 result_stall;
	out_t                 result_beat;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// from the checker
	int mismatches;
	int reports_pending;
	int reports_checked;

	// stimulus bookkeeping
	logic [7:0] list_bytes[$];
	logic       quiet;
	logic       hold_req;
	logic       tgt_known;
	kind_t      tgt_kind;
	logic [7:0] tgt;
	logic [7:0] occ;
	int         bytes_sent;
	int         lists_sent;
	int         settings_applied;

	property_list_scanner_core dut (.*);

	scan_report_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling: far above a full run with worst-case idling and the long hold-off
	initial begin
		#1_000_000;
		$display("** property_list_scanner_core: FAILED **");
		$display("timeout: the run did not drain");
		$finish;
	end

	// result side: random stall bursts, one long hold-off on request,
	// and no stalls once the run goes quiet
	initial begin
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 99) < 20) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// an identifier of the given datatype from the mqtt 5 property table
	function automatic logic [7:0] pick_id(input kind_t k);
		logic [7:0] id;
		case (k)
			K_BYTE: begin
				case ($urandom_range(0, 7))
					0:       id = 8'h01;
					1:       id = 8'h17;
					2:       id = 8'h19;
					3:       id = 8'h24;
					4:       id = 8'h25;
					5:       id = 8'h28;
					6:       id = 8'h29;
					default: id = 8'h2A;
				endcase
			end
			K_TWO: begin
				case ($urandom_range(0, 3))
					0:       id = 8'h13;
					1:       id = 8'h21;
					2:       id = 8'h22;
					default: id = 8'h23;
				endcase
			end
			K_FOUR: begin
				case ($urandom_range(0, 3))
					0:       id = 8'h02;
					1:       id = 8'h11;
					2:       id = 8'h18;
					default: id = 8'h27;
				endcase
			end
			K_VARINT: id = 8'h0B;
			K_STRING: begin
				case ($urandom_range(0, 6))
					0:       id = 8'h03;
					1:       id = 8'h08;
					2:       id = 8'h12;
					3:       id = 8'h15;
					4:       id = 8'h1A;
					5:       id = 8'h1C;
					default: id = 8'h1F;
				endcase
			end
			K_DATA:  id = ($urandom_range(0, 1) == 0) ? 8'h09 : 8'h16;
			default: id = 8'h26;
		endcase
		return id;
	endfunction

	// one more byte at the tail of the list being built
	task automatic append_byte(input logic [7:0] b);
		list_bytes.insert(list_bytes.size(), b);
	endtask

	// length-prefixed text, mostly short, now and then past one prefix byte
	task automatic add_text();
		int len;
		len = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
		append_byte(len[15:8]);
		append_byte(len[7:0]);
		repeat (len) append_byte(8'($urandom_range(0, 255)));
	endtask

	// one well-formed property with random content
	task automatic add_property(input kind_t k, input logic [7:0] id);
		int n;
		append_byte(id);
		case (k)
			K_BYTE, K_TWO, K_FOUR: begin
				n = (k == K_BYTE) ? 1 : (k == K_TWO) ? 2 : 4;
				repeat (n) append_byte(8'($urandom_range(0, 255)));
			end
			K_VARINT: begin
				// continuation bit on every byte but the last
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					append_byte({i != n - 1, 7'($urandom_range(0, 127))});
			end
			K_PAIR: begin
				add_text();
				add_text();
			end
			default: add_text();
		endcase
	endtask

	// one list byte beat; an optional idle burst first, valid then held
	// until the beat is taken
	task automatic put_byte(input logic [7:0] b, input logic last);
		logic taken;
		if (!quiet && $urandom_range(0, 99) < 25) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= {b, last};
		do begin
			@(negedge clk);
			taken = !byte_stall;
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
	endtask

	task automatic send_list();
		for (int i = 0; i < list_bytes.size(); i++)
			put_byte(list_bytes[i], i == list_bytes.size() - 1);
		list_bytes.delete();
		lists_sent++;
	endtask

	// sender pause: no byte beats until every report is in, then an idle
	// wait so the block is surely idle
	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(negedge clk); while (reports_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// both registers back to back, valid held across the two beats
	task automatic apply_config(input logic [7:0] want_id, input logic [7:0] want_nth);
		logic done;
		for (int r = 0; r < 2; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (r == 0) ? REG_TARGET_ID : REG_OCCURRENCE;
			cfg_data  <= (r == 0) ? want_id : want_nth;
			do begin
				@(negedge clk);
				done = cfg_ready;
				@(posedge clk);
			end while (!done);
		end
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	initial begin : stimulus
		int    phase_bytes;
		int    guard;
		int    drop;
		kind_t k;

		arst_n           = 1'b0;
		byte_valid       = 1'b0;
		byte_beat        = '0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		quiet            = 1'b0;
		hold_req         = 1'b0;
		tgt_known        = 1'b0;
		tgt_kind         = K_BYTE;
		tgt              = '0;
		occ              = '0;
		bytes_sent       = 0;
		lists_sent       = 0;
		settings_applied = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: string pair target, second string empty
		apply_config(8'h26, 8'h00);
		list_bytes = '{8'h26, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00};
		send_list();

		// second varint match at its largest value, then a bad varint
		wait_drained();
		apply_config(8'h0B, 8'h01);
		list_bytes = '{8'h0B, 8'h7F, 8'h0B, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
		send_list();
		list_bytes = '{8'h0B, 8'h80, 8'h80, 8'h80, 8'h80};
		send_list();

		// unknown id, all-ones four-byte target with an unknown id after it,
		// target cut short, clean list without the target
		wait_drained();
		apply_config(8'h27, 8'h00);
		list_bytes = '{8'h00};
		send_list();
		list_bytes = '{8'h27, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_list();
		list_bytes = '{8'h27, 8'h00, 8'h00};
		send_list();
		list_bytes = '{8'h01, 8'h00};
		send_list();

		// zero-length data target with a trailing byte
		wait_drained();
		apply_config(8'h16, 8'h00);
		list_bytes = '{8'h16, 8'h00, 8'h00, 8'hAA};
		send_list();

		// random phases, one register setting each
		for (int ph = 0; ph < 10; ph++) begin
			wait_drained();
			if (ph == 0) begin
				tgt_known = 1'b0;
				tgt       = 8'hFF;
				occ       = 8'h00;
			end else if (ph == 1) begin
				tgt_known = 1'b0;
				tgt       = 8'h00;
				occ       = 8'hFF;
			end else begin
				tgt_known = 1'b1;
				tgt_kind  = kind_t'($urandom_range(0, 6));
				tgt       = pick_id(tgt_kind);
				occ       = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 3)) : 8'h00;
			end
			apply_config(tgt, occ);
			if (ph >= 8)
				quiet = 1'b1;

			// back-pressure: one-byte lists while the receiver holds off
			if (ph == 4) begin
				hold_req = 1'b1;
				repeat (12) begin
					append_byte(8'($urandom_range(0, 255)));
					send_list();
				end
			end

			phase_bytes = 0;
			while (phase_bytes < 40) begin
				repeat ($urandom_range(1, 5)) begin
					if (tgt_known && $urandom_range(0, 99) < 35)
						add_property(tgt_kind, tgt);
					else begin
						k = kind_t'($urandom_range(0, 6));
						add_property(k, pick_id(k));
					end
				end
				// most lists stay well formed, the rest get broken
				case ($urandom_range(0, 9))
					0: begin
						// cut off inside or after some property
						if (list_bytes.size() > 1) begin
							drop = $urandom_range(1, list_bytes.size() - 1);
							repeat (drop) list_bytes.delete(list_bytes.size() - 1);
						end
					end
					1: begin
						append_byte(8'($urandom_range(8'h2B, 8'hFF)));
						k = kind_t'($urandom_range(0, 6));
						add_property(k, pick_id(k));
					end
					2: begin
						append_byte(8'h0B);
						repeat (4) append_byte(8'h80 | 8'($urandom_range(0, 127)));
					end
					3: begin
						list_bytes.delete();
						repeat ($urandom_range(1, 8))
							append_byte(8'($urandom_range(0, 255)));
					end
					default: ;
				endcase
				phase_bytes += list_bytes.size();
				send_list();
			end
		end

		// end of run: wait out every report, then the output stage
		byte_valid <= 1'b0;
		guard = 0;
		@(negedge clk);
		while (reports_pending != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);

		$display("run covered %0d list bytes in %0d lists under %0d register settings,",
			bytes_sent, lists_sent, settings_applied);
		$display("with broken, cut and back-pressured lists; %0d reports compared, %0d left over",
			reports_checked, reports_pending);
		if (mismatches == 0 && reports_pending == 0) begin
			$display("** property_list_scanner_core: PASSED **");
		end else begin
			$display("** property_list_scanner_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
design/pls_pkg.sv
design/pls_step.sv
design/property_list_scanner_core.sv
tb/scan_report_checker.sv
tb/testbench.sv
